### src/rpy_pkg.sv
// Shared types, widths and constants of the roll/pitch/yaw to rotation vector unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package rpy_pkg;

  // Datapath widths
  localparam int DW           = 36;   // signed Q30 working width
  localparam int CORDIC_ITERS = 30;
  localparam int SC_LAT       = CORDIC_ITERS + 2;
  localparam int ISQ_STEPS    = 31;
  localparam int SQW          = 62;
  localparam int NUMW         = 64;
  localparam int DENW         = 52;
  localparam int QW           = 21;
  localparam int OUTW         = 20;
  localparam int PIPE_LAT     = 126;

  // Q30 constants
  localparam logic signed [DW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [DW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [DW-1:0] CORDIC_K    = 36'sd652032874;
  localparam logic signed [DW-1:0] Q_ONE       = 36'sd1073741824;

  // Output saturation limits
  localparam logic [QW-1:0] OUT_POS_MAX = 21'd524287;
  localparam logic [QW-1:0] OUT_NEG_MAX = 21'd524288;

  // atan(2^-i) in Q30, rounded to nearest
  localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
    32'd32,        32'd16,        32'd8,         32'd4,         32'd2
  };

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } in_t;

  typedef struct packed {
    logic signed [OUTW-1:0] rot_x;
    logic signed [OUTW-1:0] rot_y;
    logic signed [OUTW-1:0] rot_z;
    logic                   degenerate;
  } out_t;

  typedef struct packed {
    logic signed [DW-1:0] cos_v;
    logic signed [DW-1:0] sin_v;
  } sc_out_t;

  typedef struct packed {
    logic [2:0][NUMW-1:0] num;
    logic [DENW-1:0]      den;
    logic [2:0]           neg;
    logic                 zero;
  } div_in_t;

  typedef struct packed {
    logic [2:0][QW-1:0] q;
    logic [2:0]         ovf;
    logic [2:0]         neg;
    logic               zero;
  } div_out_t;

endpackage

### src/rpy_sincos.sv
// Pipelined CORDIC sine/cosine, one iteration per stage.
// Depends on rpy_pkg.
`timescale 1ns / 1ps

module rpy_sincos import rpy_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [DW-1:0] in_ang,
  output logic                 out_vld,
  output sc_out_t              out_sc
);

  localparam int N = CORDIC_ITERS;

  logic signed [DW-1:0] x_r [N+1];
  logic signed [DW-1:0] y_r [N+1];
  logic signed [DW-1:0] z_r [N];
  logic                 flip_r [N+1];
  logic                 vld_r [N+1];
  logic signed [DW-1:0] z_pre;
  logic                 flip_pre;
  logic                 out_vld_r;
  sc_out_t              out_sc_r;

  // fold angles beyond +-pi/2 by pi, negate at the end
  always_comb begin
    z_pre    = in_ang;
    flip_pre = 1'b0;
    if (in_ang > HALF_PI_Q30) begin
      z_pre    = in_ang - PI_Q30;
      flip_pre = 1'b1;
    end else if (in_ang < -HALF_PI_Q30) begin
      z_pre    = in_ang + PI_Q30;
      flip_pre = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= CORDIC_K;
    y_r[0]    <= '0;
    z_r[0]    <= z_pre;
    flip_r[0] <= flip_pre;
  end

  // rotation stages
  for (genvar i = 0; i < N; i++) begin : g_it
    localparam logic signed [DW-1:0] STEP = $signed({{(DW-32){1'b0}}, ATAN_TAB[i]});
    logic signed [DW-1:0] x_nxt;
    logic signed [DW-1:0] y_nxt;

    always_comb begin
      if (!z_r[i][DW-1]) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      x_r[i+1]    <= x_nxt;
      y_r[i+1]    <= y_nxt;
      flip_r[i+1] <= flip_r[i];
    end

    if (i < N - 1) begin : g_z
      always_ff @(posedge clk) begin
        z_r[i+1] <= z_r[i][DW-1] ? z_r[i] + STEP : z_r[i] - STEP;
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    out_sc_r.cos_v <= flip_r[N] ? -x_r[N] : x_r[N];
    out_sc_r.sin_v <= flip_r[N] ? -y_r[N] : y_r[N];
  end

  assign out_vld = out_vld_r;
  assign out_sc  = out_sc_r;

endmodule

### src/rpy_divider.sv
// Three-lane pipelined restoring divider with a shared divisor, one quotient bit a stage.
// Depends on rpy_pkg.
`timescale 1ns / 1ps

module rpy_divider import rpy_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  input  div_in_t  in_div,
  output logic     out_vld,
  output div_out_t out_div
);

  localparam int CW = DENW + QW;

  logic [2:0][NUMW-1:0] rem_r [QW];
  logic [2:0][QW-1:0]   q_r   [QW+1];
  logic [DENW-1:0]      den_r [QW+1];
  logic [2:0]           ovf_r [QW+1];
  logic [2:0]           neg_r [QW+1];
  logic                 zero_r [QW+1];
  logic                 vld_r [QW+1];
  logic [2:0]           ovf_nxt;

  // quotient would not fit in QW bits
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ovf_nxt[l] = (in_div.num[l] >> QW) >= NUMW'(in_div.den);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= in_div.num;
    q_r[0]    <= '0;
    den_r[0]  <= in_div.den;
    ovf_r[0]  <= ovf_nxt;
    neg_r[0]  <= in_div.neg;
    zero_r[0] <= in_div.zero;
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= QW; k++) begin : g_st
    localparam int B = QW - k;
    logic [2:0][NUMW-1:0] rem_nxt;
    logic [2:0][QW-1:0]   q_nxt;
    logic [CW-1:0]        cmp;

    always_comb begin
      cmp     = CW'(den_r[k-1]) << B;
      rem_nxt = rem_r[k-1];
      q_nxt   = q_r[k-1];
      for (int l = 0; l < 3; l++) begin
        if (CW'(rem_r[k-1][l]) >= cmp) begin
          rem_nxt[l]  = NUMW'(CW'(rem_r[k-1][l]) - cmp);
          q_nxt[l][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      q_r[k]    <= q_nxt;
      den_r[k]  <= den_r[k-1];
      ovf_r[k]  <= ovf_r[k-1];
      neg_r[k]  <= neg_r[k-1];
      zero_r[k] <= zero_r[k-1];
    end

    if (k < QW) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt;
      end
    end
  end

  assign out_vld      = vld_r[QW];
  assign out_div.q    = q_r[QW];
  assign out_div.ovf  = ovf_r[QW];
  assign out_div.neg  = neg_r[QW];
  assign out_div.zero = zero_r[QW];

endmodule

### src/rpy_to_rotation_vector_unit.sv
// Top level: roll/pitch/yaw binary angles to a saturated Q-format rotation vector.
// Depends on rpy_pkg, rpy_sincos and rpy_divider.
`timescale 1ns / 1ps

// Usage
//   Input: an item (roll, pitch, yaw on in_data) transfers at a rising edge with
//   start high and busy low. busy is low whenever rst_n is high, so one item can
//   transfer in every cycle.
//   Output: each item gives one result on out_data, marked by out_strobe for one
//   cycle; the receiver takes it at the edge ending that cycle and cannot stall.
//   Throughput: one item per cycle. The pipeline is set by the three CORDIC
//   sine/cosine units (32 stages), the matrix multiply stages, a 31-stage square
//   root, a 31-stage CORDIC arctangent, a split 64-bit product and a 22-stage
//   divider, each stage one register deep.
//   Reset: synchronous, active low; it clears every valid bit, so items in
//   flight are dropped and no strobe appears in the cycle after reset.
//   Degenerate poses (sine of the angle zero) give a zero vector with the
//   degenerate flag set.

module rpy_to_rotation_vector_unit import rpy_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  in_t  in_data,
  output logic busy,
  output logic out_strobe,
  output out_t out_data
);

  localparam int N  = CORDIC_ITERS;
  localparam int PW = ANGLE_BITS + 32;
  localparam logic [31:0]           PI_U  = PI_Q30[31:0];
  localparam logic signed [DW-1:0]  PI2   = PI_Q30 <<< 1;
  localparam logic signed [2*DW-1:0] QRND = (2*DW)'(1) <<< 29;
  localparam logic signed [DW+1:0]  C_MAX = (DW+2)'(Q_ONE);
  localparam logic [SQW-1:0]        ONE_SQ = SQW'(1) << 60;

  typedef struct packed {
    logic signed [DW-1:0] d0;
    logic signed [DW-1:0] d1;
    logic signed [DW-1:0] d2;
    logic                 rn;
  } side_t;

  // Q30 multiply, rounded half up
  function automatic logic signed [DW-1:0] qmul(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [2*DW-1:0] p;
    p = a * b + QRND;
    return p[DW+29:30];
  endfunction

  assign busy = ~rst_n;

  // ---------------- input register ----------------
  in_t  in_r;
  logic v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_data;
  end

  // ---------------- binary angle to Q30 radians ----------------
  logic signed [15:0]   fld [3];
  logic signed [DW-1:0] rad_nxt [3];
  logic signed [DW-1:0] rad_r [3];
  logic                 v1_r;
  logic                 rn_r;

  assign fld[0] = in_r.roll;
  assign fld[1] = in_r.pitch;
  assign fld[2] = in_r.yaw;

  for (genvar j = 0; j < 3; j++) begin : g_rad
    logic signed [31:0]         ext;
    logic signed [ANGLE_BITS-1:0] w;
    logic [ANGLE_BITS-1:0]      mag;
    logic [PW-1:0]              prod;
    logic [31:0]                r;

    assign ext  = 32'(fld[j]);
    assign w    = ext[ANGLE_BITS-1:0];
    assign mag  = w[ANGLE_BITS-1] ? unsigned'(-w) : unsigned'(w);
    assign prod = PW'(mag) * PW'(PI_U) + (PW'(1) << (ANGLE_BITS - 2));
    assign r    = 32'(prod >> (ANGLE_BITS - 1));
    assign rad_nxt[j] = w[ANGLE_BITS-1] ? -$signed(DW'(r)) : $signed(DW'(r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    rad_r <= rad_nxt;
    rn_r  <= rad_nxt[0][DW-1];
  end

  // ---------------- sine / cosine ----------------
  sc_out_t sc [3];
  logic    sc_vld [3];

  for (genvar j = 0; j < 3; j++) begin : g_sc
    rpy_sincos u_sc (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (v1_r),
      .in_ang  (rad_r[j]),
      .out_vld (sc_vld[j]),
      .out_sc  (sc[j])
    );
  end

  // roll sign follows the sine/cosine latency
  logic rn_dly_r [SC_LAT];

  always_ff @(posedge clk) begin
    rn_dly_r[0] <= rn_r;
    for (int k = 1; k < SC_LAT; k++) begin
      rn_dly_r[k] <= rn_dly_r[k-1];
    end
  end

  logic signed [DW-1:0] cr, sr, cp, sp, cy, sy;
  assign cr = sc[0].cos_v;
  assign sr = sc[0].sin_v;
  assign cp = sc[1].cos_v;
  assign sp = sc[1].sin_v;
  assign cy = sc[2].cos_v;
  assign sy = sc[2].sin_v;

  // ---------------- pairwise products ----------------
  logic signed [DW-1:0] cycp_r, cysp_r, sycr_r, sysr_r, sycp_r, sysp_r;
  logic signed [DW-1:0] cycr_r, cysr_r, cpsr_r, cpcr_r, sp1_r, sr1_r, cr1_r;
  logic                 vm1_r, rnm1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
    end else begin
      vm1_r <= sc_vld[0] & sc_vld[1] & sc_vld[2];
    end
  end

  always_ff @(posedge clk) begin
    cycp_r <= qmul(cy, cp);
    cysp_r <= qmul(cy, sp);
    sycr_r <= qmul(sy, cr);
    sysr_r <= qmul(sy, sr);
    sycp_r <= qmul(sy, cp);
    sysp_r <= qmul(sy, sp);
    cycr_r <= qmul(cy, cr);
    cysr_r <= qmul(cy, sr);
    cpsr_r <= qmul(cp, sr);
    cpcr_r <= qmul(cp, cr);
    sp1_r  <= sp;
    sr1_r  <= sr;
    cr1_r  <= cr;
    rnm1_r <= rn_dly_r[SC_LAT-1];
  end

  // ---------------- matrix elements ----------------
  logic signed [DW-1:0] m00_r, m01_r, m02_r, m10_r, m11_r, m12_r, m20_r, m21_r, m22_r;
  logic                 vm2_r, rnm2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm2_r <= 1'b0;
    end else begin
      vm2_r <= vm1_r;
    end
  end

  always_ff @(posedge clk) begin
    m00_r  <= cycp_r;
    m01_r  <= qmul(cysp_r, sr1_r) - sycr_r;
    m02_r  <= qmul(cysp_r, cr1_r) + sysr_r;
    m10_r  <= sycp_r;
    m11_r  <= qmul(sysp_r, sr1_r) + cycr_r;
    m12_r  <= qmul(sysp_r, cr1_r) - cysr_r;
    m20_r  <= -sp1_r;
    m21_r  <= cpsr_r;
    m22_r  <= cpcr_r;
    rnm2_r <= rnm1_r;
  end

  // ---------------- cosine of the angle, skew differences ----------------
  logic signed [DW+1:0] tr, tr_half;
  logic signed [31:0]   c_nxt;
  logic signed [31:0]   c3_r;
  side_t                sd3_r;
  logic                 vm3_r;

  always_comb begin
    tr      = (DW+2)'(m00_r) + (DW+2)'(m11_r) + (DW+2)'(m22_r) - (DW+2)'(Q_ONE);
    tr_half = tr >>> 1;
    if (tr_half > C_MAX) begin
      c_nxt = 32'(C_MAX);
    end else if (tr_half < -C_MAX) begin
      c_nxt = 32'(-C_MAX);
    end else begin
      c_nxt = 32'(tr_half);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm3_r <= 1'b0;
    end else begin
      vm3_r <= vm2_r;
    end
  end

  always_ff @(posedge clk) begin
    c3_r     <= c_nxt;
    sd3_r.d0 <= m21_r - m12_r;
    sd3_r.d1 <= m02_r - m20_r;
    sd3_r.d2 <= m10_r - m01_r;
    sd3_r.rn <= rnm2_r;
  end

  // ---------------- c squared ----------------
  logic signed [63:0] cc_r;
  logic signed [31:0] csq_r;
  side_t              sdsq_r;
  logic               vsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsq_r <= 1'b0;
    end else begin
      vsq_r <= vm3_r;
    end
  end

  always_ff @(posedge clk) begin
    cc_r   <= c3_r * c3_r;
    csq_r  <= c3_r;
    sdsq_r <= sd3_r;
  end

  // ---------------- square root, one result bit per stage ----------------
  logic [SQW-1:0]     n_init;
  logic [SQW-1:0]     n_r   [ISQ_STEPS-1];
  logic [SQW-1:0]     res_r [ISQ_STEPS];
  logic signed [31:0] cq_r  [ISQ_STEPS];
  side_t              sdq_r [ISQ_STEPS];
  logic               vq_r  [ISQ_STEPS];

  assign n_init = ONE_SQ - SQW'(unsigned'(cc_r));

  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_sq
    localparam logic [SQW-1:0] BIT = SQW'(1) << (60 - 2 * k);
    logic [SQW-1:0]     n_cur, r_cur, sum, n_nxt, r_nxt;
    logic signed [31:0] c_cur;
    side_t              sd_cur;
    logic               v_cur;

    if (k == 0) begin : g_first
      assign n_cur  = n_init;
      assign r_cur  = '0;
      assign c_cur  = csq_r;
      assign sd_cur = sdsq_r;
      assign v_cur  = vsq_r;
    end else begin : g_next
      assign n_cur  = n_r[k-1];
      assign r_cur  = res_r[k-1];
      assign c_cur  = cq_r[k-1];
      assign sd_cur = sdq_r[k-1];
      assign v_cur  = vq_r[k-1];
    end

    always_comb begin
      sum = r_cur + BIT;
      if (n_cur >= sum) begin
        n_nxt = n_cur - sum;
        r_nxt = (r_cur >> 1) + BIT;
      end else begin
        n_nxt = n_cur;
        r_nxt = r_cur >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vq_r[k] <= 1'b0;
      end else begin
        vq_r[k] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      res_r[k] <= r_nxt;
      cq_r[k]  <= c_cur;
      sdq_r[k] <= sd_cur;
    end

    if (k < ISQ_STEPS - 1) begin : g_n
      always_ff @(posedge clk) begin
        n_r[k] <= n_nxt;
      end
    end
  end

  // ---------------- arctangent by CORDIC vectoring ----------------
  logic [30:0]          s_q;
  logic signed [DW-1:0] c_ext, s_ext, ax_pre, ay_pre, az_pre;
  logic signed [DW-1:0] ax_r [N];
  logic signed [DW-1:0] ay_r [N];
  logic signed [DW-1:0] az_r [N+1];
  logic [30:0]          sa_r [N+1];
  side_t                sda_r [N+1];
  logic                 va_r [N+1];

  assign s_q   = res_r[ISQ_STEPS-1][30:0];
  assign c_ext = DW'(cq_r[ISQ_STEPS-1]);
  assign s_ext = $signed(DW'(s_q));

  // left half plane: turn by -pi/2 first
  always_comb begin
    if (c_ext[DW-1]) begin
      ax_pre = s_ext;
      ay_pre = -c_ext;
      az_pre = HALF_PI_Q30;
    end else begin
      ax_pre = c_ext;
      ay_pre = s_ext;
      az_pre = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r[0] <= 1'b0;
    end else begin
      va_r[0] <= vq_r[ISQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    ax_r[0]  <= ax_pre;
    ay_r[0]  <= ay_pre;
    az_r[0]  <= az_pre;
    sa_r[0]  <= s_q;
    sda_r[0] <= sdq_r[ISQ_STEPS-1];
  end

  for (genvar i = 0; i < N; i++) begin : g_at
    localparam logic signed [DW-1:0] STEP = $signed({{(DW-32){1'b0}}, ATAN_TAB[i]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[i+1] <= 1'b0;
      end else begin
        va_r[i+1] <= va_r[i];
      end
    end

    always_ff @(posedge clk) begin
      az_r[i+1]  <= ay_r[i][DW-1] ? az_r[i] - STEP : az_r[i] + STEP;
      sa_r[i+1]  <= sa_r[i];
      sda_r[i+1] <= sda_r[i];
    end

    if (i < N - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (!ay_r[i][DW-1]) begin
          ax_r[i+1] <= ax_r[i] + (ay_r[i] >>> i);
          ay_r[i+1] <= ay_r[i] - (ax_r[i] >>> i);
        end else begin
          ax_r[i+1] <= ax_r[i] - (ay_r[i] >>> i);
          ay_r[i+1] <= ay_r[i] + (ax_r[i] >>> i);
        end
      end
    end
  end

  // ---------------- theta, magnitudes, divisor ----------------
  side_t                sd_a;
  logic signed [DW-1:0] th_r;
  logic [DW-1:0]        mag_r [3];
  logic [2:0]           negt_r;
  logic [DENW-1:0]      dent_r;
  logic                 zerot_r, vt_r;
  logic signed [DW-1:0] dsel [3];

  assign sd_a    = sda_r[N];
  assign dsel[0] = sd_a.d0;
  assign dsel[1] = sd_a.d1;
  assign dsel[2] = sd_a.d2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
    end else begin
      vt_r <= va_r[N];
    end
  end

  always_ff @(posedge clk) begin
    th_r    <= sd_a.rn ? PI2 - az_r[N] : az_r[N];
    dent_r  <= DENW'(sa_r[N]) << (31 - FRAC_BITS);
    zerot_r <= (sa_r[N] == '0);
    for (int l = 0; l < 3; l++) begin
      mag_r[l]  <= dsel[l][DW-1] ? unsigned'(-dsel[l]) : unsigned'(dsel[l]);
      negt_r[l] <= dsel[l][DW-1] ^ sd_a.rn;
    end
  end

  // ---------------- 64-bit product, split in two halves ----------------
  logic [63:0]     th64;
  logic [63:0]     pl_r [3];
  logic [31:0]     ph_r [3];
  logic [2:0]      negp_r;
  logic [DENW-1:0] denp_r;
  logic            zerop_r, vp_r;

  assign th64 = 64'(th_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else begin
      vp_r <= vt_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      pl_r[l] <= 64'((DW+32)'(mag_r[l]) * (DW+32)'(th64[31:0]));
      ph_r[l] <= 32'((DW+32)'(mag_r[l]) * (DW+32)'(th64[63:32]));
    end
    negp_r  <= negt_r;
    denp_r  <= dent_r;
    zerop_r <= zerot_r;
  end

  // numerator with half the divisor added, wrapping at 64 bits
  div_in_t di_r;
  logic    vd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= vp_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      di_r.num[l] <= pl_r[l] + {ph_r[l], 32'd0} + NUMW'(denp_r >> 1);
    end
    di_r.den  <= denp_r;
    di_r.neg  <= negp_r;
    di_r.zero <= zerop_r;
  end

  // ---------------- divide ----------------
  div_out_t dv;
  logic     dv_vld;

  rpy_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vd_r),
    .in_div  (di_r),
    .out_vld (dv_vld),
    .out_div (dv)
  );

  // ---------------- sign, saturation, output register ----------------
  logic signed [OUTW-1:0] rot_nxt [3];
  out_t                   out_r;
  logic                   strobe_r;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv.zero) begin
        rot_nxt[l] = '0;
      end else if (!dv.neg[l]) begin
        rot_nxt[l] = (dv.ovf[l] || dv.q[l] > OUT_POS_MAX) ? $signed(OUTW'(OUT_POS_MAX))
                                                          : $signed(OUTW'(dv.q[l]));
      end else begin
        rot_nxt[l] = (dv.ovf[l] || dv.q[l] > OUT_NEG_MAX) ? $signed(OUTW'(-OUT_NEG_MAX))
                                                          : $signed(OUTW'(-dv.q[l]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r.rot_x      <= rot_nxt[0];
    out_r.rot_y      <= rot_nxt[1];
    out_r.rot_z      <= rot_nxt[2];
    out_r.degenerate <= dv.zero;
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

### src/rpy_checker.sv
// Port-level checks of the rotation vector unit, bound to its top level.
// Depends on rpy_pkg and rpy_to_rotation_vector_unit.
`timescale 1ns / 1ps

module rpy_unit_props import rpy_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input out_t out_data
);

  // a degenerate pose carries a zero vector
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.degenerate |->
      out_data.rot_x == '0 && out_data.rot_y == '0 && out_data.rot_z == '0)
    else $error("degenerate result with nonzero vector");

  // every result comes from a transfer a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, PIPE_LAT))
    else $error("result without matching input transfer");

  // reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_strobe)
    else $error("strobe right after reset");

  // input side never refuses out of reset
  a_not_busy: assert property (@(posedge clk)
    rst_n |-> !busy)
    else $error("busy while out of reset");

endmodule

bind rpy_to_rotation_vector_unit rpy_unit_props u_chk (.*);

### verif/rpy_checker.sv
// Checker for rpy_to_rotation_vector_unit: watches input and result transfers,
// predicts each result in fixed point and compares field by field. Depends on rpy_pkg.
`timescale 1ns / 1ps

module rpy_checker import rpy_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_data,
  input  logic out_strobe,
  input  out_t out_data,
  output int   mismatches,
  output int   outstanding
);

  localparam longint ONE = 64'sd1 << 30;
  localparam longint PI  = 64'sd3373259426;
  localparam longint HPI = 64'sd1686629713;
  localparam longint KGAIN = 64'sd652032874;

  longint atan_step [30];
  out_t   pose_q [$];

  // atan(2^-i) in Q30: pi/4 for i = 0, else from the odd power series; rounded to nearest
  initial begin
    longint acc;
    longint ex;
    longint term;
    for (int i = 0; i < 30; i++) begin
      if (i == 0) begin
        atan_step[i] = (PI + 2) >>> 2;
      end else begin
        acc = 0;
        for (int k = 0; k < 64; k++) begin
          ex = 60 - i * (2 * k + 1);
          if (ex < 0) break;
          term = (64'sd1 << ex) / (2 * k + 1);
          acc = (k % 2) ? acc - term : acc + term;
        end
        atan_step[i] = (acc + (64'sd1 << 29)) >>> 30;
      end
    end
  end

  function automatic longint fmul(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic void rot_sincos(longint ang, output longint c, output longint s);
    longint x, y, z, nx, ny;
    bit flip;
    x = KGAIN; y = 0; z = ang; flip = 0;
    if (z > HPI) begin
      z -= PI; flip = 1;
    end else if (z < -HPI) begin
      z += PI; flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_step[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_step[i];
      end
      x = nx; y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // angle of (x, y) for y >= 0, in [0, pi]
  function automatic longint vec_angle(longint y, longint x);
    longint z, nx, ny, t;
    z = 0;
    if (x < 0) begin
      t = x; x = y; y = -t; z = HPI;
    end
    for (int i = 0; i < 30; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_step[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_step[i];
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0; b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b; res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint to_rad(logic signed [15:0] a);
    longint w;
    longint unsigned mag, r;
    w = a;
    mag = (w < 0) ? -w : w;
    r = (mag * 64'(PI) + (64'd1 << 14)) >> 15;
    return (w < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [OUTW-1:0] scale_axis(longint d, longint unsigned theta,
                                                 longint unsigned s, bit sin_neg);
    longint unsigned mag, den, q;
    bit neg;
    mag = (d < 0) ? -d : d;
    den = s << 15;
    q = (mag * theta + den / 2) / den;
    neg = (d < 0) != sin_neg;
    if (!neg) return (q > 524287) ? 20'd524287 : q[OUTW-1:0];
    if (q > 524288) q = 524288;
    return OUTW'(-longint'(q));
  endfunction

  function automatic out_t predict_rotvec(in_t p);
    longint r, pt, yw, cr, sr, cp, sp, cy, sy;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22, c, alpha;
    longint unsigned s, theta;
    bit roll_neg;
    out_t o;
    roll_neg = p.roll < 0;
    r = to_rad(p.roll); pt = to_rad(p.pitch); yw = to_rad(p.yaw);
    rot_sincos(r, cr, sr);
    rot_sincos(pt, cp, sp);
    rot_sincos(yw, cy, sy);
    m00 = fmul(cy, cp);
    m01 = fmul(fmul(cy, sp), sr) - fmul(sy, cr);
    m02 = fmul(fmul(cy, sp), cr) + fmul(sy, sr);
    m10 = fmul(sy, cp);
    m11 = fmul(fmul(sy, sp), sr) + fmul(cy, cr);
    m12 = fmul(fmul(sy, sp), cr) - fmul(cy, sr);
    m20 = -sp;
    m21 = fmul(cp, sr);
    m22 = fmul(cp, cr);
    c = (m00 + m11 + m22 - ONE) >>> 1;
    if (c > ONE) c = ONE;
    if (c < -ONE) c = -ONE;
    s = int_sqrt(64'(ONE * ONE - c * c));
    alpha = vec_angle(longint'(s), c);
    theta = roll_neg ? 2 * PI - alpha : alpha;
    o = '0;
    if (s == 0) begin
      o.degenerate = 1'b1;
    end else begin
      o.rot_x = scale_axis(m21 - m12, theta, s, roll_neg);
      o.rot_y = scale_axis(m02 - m20, theta, s, roll_neg);
      o.rot_z = scale_axis(m10 - m01, theta, s, roll_neg);
    end
    return o;
  endfunction

  assign outstanding = pose_q.size();

  initial mismatches = 0;

  // predict on input transfer, compare on result transfer
  always @(posedge clk) begin
    out_t exp_v;
    if (rst_n && start && !busy) pose_q.push_back(predict_rotvec(in_data));
    if (rst_n && out_strobe) begin
      if (pose_q.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        exp_v = pose_q.pop_front();
        if (out_data.rot_x !== exp_v.rot_x) begin
          $error("rot_x: expected %0d actual %0d", exp_v.rot_x, out_data.rot_x);
          mismatches++;
        end
        if (out_data.rot_y !== exp_v.rot_y) begin
          $error("rot_y: expected %0d actual %0d", exp_v.rot_y, out_data.rot_y);
          mismatches++;
        end
        if (out_data.rot_z !== exp_v.rot_z) begin
          $error("rot_z: expected %0d actual %0d", exp_v.rot_z, out_data.rot_z);
          mismatches++;
        end
        if (out_data.degenerate !== exp_v.degenerate) begin
          $error("degenerate: expected %0b actual %0b", exp_v.degenerate,
                 out_data.degenerate);
          mismatches++;
        end
      end
    end
  end

endmodule

### verif/tb_rpy_to_rotation_vector_unit.sv
// Testbench top for rpy_to_rotation_vector_unit: drives directed and random poses
// with varying input gaps; gives the verdict. Depends on it, rpy_pkg, rpy_checker.
`timescale 1ns / 1ps

module tb_rpy_to_rotation_vector_unit;
  import rpy_pkg::*;

  logic clk, rst_n, start, busy, out_strobe;
  in_t  in_data;
  out_t out_data;
  int   mismatches, outstanding;
  int   gap_pct;

  rpy_to_rotation_vector_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data),
    .busy(busy), .out_strobe(out_strobe), .out_data(out_data)
  );

  rpy_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // hard stop
  initial begin
    #5_000_000;
    $display("rpy_to_rotation_vector_unit regression: fail");
    $finish;
  end

  // one pose transfer, preceded by random idle cycles; called at a falling edge
  task automatic send_pose(logic [15:0] r, logic [15:0] p, logic [15:0] y);
    logic was_busy;
    int idle;
    idle = 0;
    while ($urandom_range(99) < gap_pct && idle < 40) idle++;
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= '{roll: r, pitch: p, yaw: y};
    do begin
      was_busy = busy;
      @(negedge clk);
    end while (was_busy);
  endtask

  function automatic logic [15:0] rnd_angle();
    case ($urandom_range(3))
      0:       return 16'($signed($urandom_range(64)) - 32);   // near zero
      1:       return 16'($urandom_range(3) * 16384 + $urandom_range(8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] ext [8];
    ext = '{16'h0000, 16'h8000, 16'h7fff, 16'h4000, 16'hc000, 16'h0001, 16'hffff,
            16'h2000};
    start   = 1'b0;
    in_data = '0;
    gap_pct = 0;
    rst_n   = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: identity, half turns, minus-pi roll, tiny negative roll, extremes
    for (int i = 0; i < 8; i++) send_pose(ext[i], 16'h0000, 16'h0000);
    for (int i = 0; i < 8; i++) send_pose(16'h0000, ext[i], ext[7 - i]);
    send_pose(16'h8000, 16'h8000, 16'h8000);
    send_pose(16'h7fff, 16'h7fff, 16'h7fff);
    send_pose(16'h8000, 16'h7fff, 16'h0001);
    send_pose(16'hffff, 16'hffff, 16'hffff);
    send_pose(16'h5555, 16'haaaa, 16'h5555);
    send_pose(16'haaaa, 16'h5555, 16'haaaa);

    // hold off until the pipeline drains
    start <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);

    // random phases with different sender gap rates
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: gap_pct = 0;
        1: gap_pct = 64;
        2: gap_pct = 25;
        default: gap_pct = $urandom_range(90);
      endcase
      repeat (200) send_pose(rnd_angle(), rnd_angle(), rnd_angle());
    end
    start <= 1'b0;

    wait (outstanding == 0);
    repeat (PIPE_LAT + 10) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("rpy_to_rotation_vector_unit regression: pass");
    end else begin
      $display("rpy_to_rotation_vector_unit regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
src/rpy_pkg.sv
src/rpy_sincos.sv
src/rpy_divider.sv
src/rpy_to_rotation_vector_unit.sv
src/rpy_checker.sv
verif/rpy_checker.sv
verif/tb_rpy_to_rotation_vector_unit.sv
